// ----- hdl/bba_pkg.sv -----
// Shared types and constants for the block bitmap allocator.
package bba_pkg;

  localparam int WORD_W      = 64;
  localparam int BIT_W       = 6;
  localparam int BIDX_W      = 10;
  localparam int STAT_W      = 2;
  localparam int CNT_W       = 11;
  localparam int SCAN_W      = 5;
  localparam int GRANT_LIMIT = 1024;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd2;

  typedef struct packed {
    logic clr;
    logic load;
    logic free_rd;
    logic free_chk;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/block_bitmap_allocator.sv -----
// Block allocator top level: register port, sequencer and map datapath.
// Allocate: after accept, the scan reads one 64-bit map word per cycle (words below the
// block count) through the read register, and the result word is then handed off.
// Free: accept, map word read, bit check and clear, hand-off. One request is in
// progress at a time; the next word is taken while the previous result waits in
// the output register. After reset a clearing pass writes one map word per cycle
// over ceil(MAX_BLOCKS/64) words, with in_tready low; total_blocks resets to 1024.
module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [9:0] block_index
  input  logic [0:0]  in_tuser,    // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [9:0] granted_block, [11:10] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bba_pkg::*;

  localparam logic REG_TOTAL = 1'b0;

  logic [CNT_W-1:0] total_blocks_r;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= CNT_W'(GRANT_LIMIT);
    end else if (cfg_wr && cfg_paddr[2] == REG_TOTAL) begin
      total_blocks_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TOTAL) ? {21'd0, total_blocks_r} : 32'd0;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser[0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .total_blocks (total_blocks_r),
    .in_index     (in_tdata[BIDX_W-1:0]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// ----- hdl/bba_ctrl.sv -----
// Sequencer for the block bitmap allocator: clear pass, request dispatch, result hand-off.
module bba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_mode,
  input  bba_pkg::stat_t stat,
  output bba_pkg::cmd_t  cmd
);
  import bba_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_FREE_RD  = 6'b000100,
    S_FREE_CHK = 6'b001000,
    S_SCAN     = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_mode == MODE_FREE) ? S_FREE_RD : S_SCAN;
        end
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- hdl/bba_dp.sv -----
// Datapath: map memory, word scan with lowest-free search, result and output registers.
module bba_dp #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bba_pkg::cmd_t             cmd,
  output bba_pkg::stat_t            stat,
  input  logic [bba_pkg::CNT_W-1:0] total_blocks,
  input  logic [bba_pkg::BIDX_W-1:0] in_index,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata
);
  import bba_pkg::*;

  localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LIM   = (MAX_BLOCKS < GRANT_LIMIT) ? MAX_BLOCKS : GRANT_LIMIT;
  localparam logic [16:0] MAP_LIM = 17'(MAX_BLOCKS);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_r;

  logic [AW-1:0]     clr_cnt_r;
  logic [BIDX_W-1:0] idx_r;
  logic [SCAN_W-1:0] nwords_r, full_r, scan_cnt_r, chk_addr_r;
  logic [BIT_W-1:0]  tail_r;
  logic              chk_v_r, started_r;
  logic [BIDX_W-1:0] res_grant_r;
  logic [STAT_W-1:0] res_status_r;
  logic              out_valid_r;
  logic [15:0]       out_data_r;

  logic [CNT_W-1:0]  eff;
  logic [CNT_W:0]    eff_rnd;
  logic [15:0]       scan_addr_w, chk_addr_w, free_addr_w;
  logic [WORD_W-1:0] vmask, free_bits;
  logic [BIT_W-1:0]  pos;
  logic              hit, exhausted, in_map, free_set;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign eff     = (total_blocks > CNT_W'(LIM)) ? CNT_W'(LIM) : total_blocks;
  assign eff_rnd = {1'b0, eff} + (CNT_W+1)'(WORD_W - 1);

  assign scan_addr_w = 16'(scan_cnt_r);
  assign chk_addr_w  = 16'(chk_addr_r);
  assign free_addr_w = 16'(idx_r[BIDX_W-1:BIT_W]);

  always_comb begin
    if (chk_addr_r < full_r) begin
      vmask = '1;
    end else if (chk_addr_r == full_r) begin
      vmask = (WORD_W'(1) << tail_r) - WORD_W'(1);
    end else begin
      vmask = '0;
    end
  end

  assign free_bits = ~rdata_r & vmask;
  assign hit       = chk_v_r && (|free_bits);
  assign exhausted = started_r && !chk_v_r;

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign in_map   = ({7'd0, idx_r} < MAP_LIM);
  assign free_set = in_map && rdata_r[idx_r[BIT_W-1:0]];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr_w[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    if (cmd.clr) begin
      wr_en = 1'b1;
    end
    if (cmd.free_rd) begin
      rd_en   = 1'b1;
      rd_addr = free_addr_w[AW-1:0];
    end
    if (cmd.free_chk && free_set) begin
      wr_en   = 1'b1;
      wr_addr = free_addr_w[AW-1:0];
      wr_data = rdata_r & ~(WORD_W'(1) << idx_r[BIT_W-1:0]);
    end
    if (cmd.scan) begin
      rd_en = (scan_cnt_r < nwords_r);
      if (hit) begin
        wr_en   = 1'b1;
        wr_addr = chk_addr_w[AW-1:0];
        wr_data = rdata_r | (WORD_W'(1) << pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      chk_v_r     <= 1'b0;
      started_r   <= 1'b0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.load) begin
        chk_v_r    <= 1'b0;
        started_r  <= 1'b0;
        scan_cnt_r <= '0;
      end else if (cmd.scan) begin
        started_r  <= 1'b1;
        chk_v_r    <= (scan_cnt_r < nwords_r);
        scan_cnt_r <= scan_cnt_r + SCAN_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r    <= in_index;
      nwords_r <= eff_rnd[CNT_W-1:BIT_W];
      full_r   <= eff[CNT_W-1:BIT_W];
      tail_r   <= eff[BIT_W-1:0];
    end
    if (cmd.scan) begin
      chk_addr_r <= scan_cnt_r;
    end
    if (cmd.free_chk) begin
      res_grant_r  <= idx_r;
      res_status_r <= free_set ? ST_OK : ST_DOUBLE;
    end else if (cmd.scan && hit) begin
      res_grant_r  <= {chk_addr_r[BIDX_W-BIT_W-1:0], pos};
      res_status_r <= ST_OK;
    end else if (cmd.scan && exhausted) begin
      res_grant_r  <= '0;
      res_status_r <= ST_FULL;
    end
    if (cmd.emit) begin
      out_data_r <= {4'd0, res_status_r, res_grant_r};
    end
  end

  assign stat.clr_last  = (clr_cnt_r == AW'(WORDS - 1));
  assign stat.scan_done = hit || exhausted;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
